@@ hw/rtl/vedet_pkg.sv @@
// Package for the vibration energy detector: field widths, register
// indexes, reset values and the constants of the baseline tracking filter.
// No dependencies.
package vedet_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int DELTA_W    = 12;
  localparam int ENERGY_W   = 32;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 96;

  localparam int BASELINE_SAMPLES_DEF = 300;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_MIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST_REQ     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_TICKS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TICKS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS    = 3'd5;

  localparam logic [DELTA_W-1:0]  DELTA_MIN_RST     = 12'd20;
  localparam logic [ENERGY_W-1:0] ENERGY_THRESH_RST = 32'd2000;
  localparam logic [COUNT_W-1:0]  PERSIST_REQ_RST   = 16'd3;
  localparam logic [COUNT_W-1:0]  WARMUP_TICKS_RST  = 16'd2000;
  localparam logic [COUNT_W-1:0]  SAMPLE_TICKS_RST  = 16'd2;
  localparam logic [COUNT_W-1:0]  WINDOW_TICKS_RST  = 16'd200;

  // (995*b + 5*x)/1000 equals b + floor((x - b)/200). The step is found by
  // a multiply with the reciprocal of 200; a negative step rounds away
  // from zero by adding 199 to the magnitude first.
  localparam int STEP_W = SAMPLE_W + 1;
  localparam logic [STEP_W-1:0] RECIP_200   = 13'd5243;
  localparam int                RECIP_SHIFT = 20;
  localparam logic [STEP_W-1:0] ROUND_UP    = 13'd199;
  localparam int                QUOT_W      = 2 * STEP_W - RECIP_SHIFT;

  function automatic logic [COUNT_W-1:0] sat_inc16(input logic [COUNT_W-1:0] v);
    sat_inc16 = (v == '1) ? v : v + COUNT_W'(1);
  endfunction

endpackage

@@ hw/rtl/vibration_energy_detector.sv @@
// Vibration energy detector top level: tick counters, baseline averaging,
// adaptive baseline, window energy and persistence logic in one pass.
// Depends on vedet_pkg.
//
// Usage:
//   Slave stream: one transfer per millisecond tick, tdata[11:0] is the ADC
//   reading. Master stream: one result per tick, the detector status after
//   that tick. Configuration: cfg_we_i writes cfg_data_i into register
//   cfg_idx_i (0 delta_min, 1 energy_threshold, 2 persistence_required,
//   3 warmup_ticks, 4 sample_ticks, 5 window_ticks); write only while idle.
//   Result: the result of a tick is registered and presented in the cycle after
//   its transfer. Throughput: one tick per cycle while results are taken; all
//   state updates of a tick, including the constant reciprocal multiplies of
//   the baseline paths, settle combinationally into the state registers.
//   Reset: state clears, registers take their defaults, no result pending.
//   Stall: while a result waits on the master side, s_axis_tready_o drops
//   unless that result is being taken in the same cycle; nothing is lost.
//   First ticks are warm-up, then BASELINE_SAMPLES ticks build the average,
//   then detection runs.
module vibration_energy_detector #(
  parameter int BASELINE_SAMPLES = vedet_pkg::BASELINE_SAMPLES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // [11:0] adc_sample
  input  logic [vedet_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [0] vibration_detected, [1] warming_up, [2] baseline_ready,
  // [14:3] baseline_level, [46:15] energy_current, [78:47] energy_last,
  // [94:79] persistence_count, [95] window_closed
  output logic [vedet_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_we_i,
  input  logic [vedet_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vedet_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import vedet_pkg::*;

  localparam int CNT_W     = $clog2(BASELINE_SAMPLES + 1);
  localparam int SUM_W     = SAMPLE_W + CNT_W;
  localparam int DIV_SHIFT = SUM_W + CNT_W;
  localparam longint unsigned DIV_MULT_L =
      ((longint'(1) << DIV_SHIFT) + longint'(BASELINE_SAMPLES) - 1) /
      longint'(BASELINE_SAMPLES);
  localparam logic [DIV_SHIFT:0] DIV_MULT = DIV_MULT_L[DIV_SHIFT:0];
  localparam int PROD_W = SUM_W + DIV_SHIFT + 1;

  // Configuration registers
  logic [DELTA_W-1:0]  delta_min_q;
  logic [ENERGY_W-1:0] energy_thresh_q;
  logic [COUNT_W-1:0]  persist_req_q;
  logic [COUNT_W-1:0]  warmup_ticks_q;
  logic [COUNT_W-1:0]  sample_ticks_q;
  logic [COUNT_W-1:0]  window_ticks_q;

  // Detector state
  logic [COUNT_W-1:0]  warmup_elapsed_q, warmup_elapsed_d;
  logic                baseline_done_q, baseline_done_d;
  logic [SUM_W-1:0]    baseline_sum_q, baseline_sum_d;
  logic [CNT_W-1:0]    baseline_taken_q, baseline_taken_d;
  logic [SAMPLE_W-1:0] baseline_q, baseline_d;
  logic [COUNT_W-1:0]  sample_elapsed_q, sample_elapsed_d;
  logic [COUNT_W-1:0]  window_elapsed_q, window_elapsed_d;
  logic [ENERGY_W-1:0] energy_q, energy_d;
  logic [ENERGY_W-1:0] closed_energy_q, closed_energy_d;
  logic [COUNT_W-1:0]  vib_windows_q, vib_windows_d;
  logic                detect_q, detect_d;
  logic                warming_q, closed_q, closed_d;
  logic                out_valid_q;

  logic                accept;
  logic [SAMPLE_W-1:0] x;
  logic                warming;

  // Baseline datapath
  logic [CNT_W-1:0]    taken_inc;
  logic [SUM_W-1:0]    sum_new;
  logic [PROD_W-1:0]   avg_prod;
  logic                x_ge_b;
  logic [SAMPLE_W-1:0] dev;
  logic [STEP_W-1:0]   step_num;
  logic [2*STEP_W-1:0] step_prod;
  logic [QUOT_W-1:0]   step_q;
  logic [STEP_W-1:0]   b_adj;
  logic [ENERGY_W:0]   energy_sum;
  logic [ENERGY_W-1:0] energy_mid;
  logic [COUNT_W-1:0]  sample_inc, window_inc, vib_next;

  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign x       = s_axis_tdata_i[SAMPLE_W-1:0];
  assign warming = warmup_elapsed_q < warmup_ticks_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_min_q     <= DELTA_MIN_RST;
      energy_thresh_q <= ENERGY_THRESH_RST;
      persist_req_q   <= PERSIST_REQ_RST;
      warmup_ticks_q  <= WARMUP_TICKS_RST;
      sample_ticks_q  <= SAMPLE_TICKS_RST;
      window_ticks_q  <= WINDOW_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DELTA_MIN:     delta_min_q     <= cfg_data_i[DELTA_W-1:0];
        REG_ENERGY_THRESH: energy_thresh_q <= cfg_data_i[ENERGY_W-1:0];
        REG_PERSIST_REQ:   persist_req_q   <= cfg_data_i[COUNT_W-1:0];
        REG_WARMUP_TICKS:  warmup_ticks_q  <= cfg_data_i[COUNT_W-1:0];
        REG_SAMPLE_TICKS:  sample_ticks_q  <= cfg_data_i[COUNT_W-1:0];
        REG_WINDOW_TICKS:  window_ticks_q  <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath pieces
  always_comb begin
    taken_inc = baseline_taken_q + CNT_W'(1);
    sum_new   = baseline_sum_q + SUM_W'(x);
    avg_prod  = PROD_W'(sum_new) * PROD_W'(DIV_MULT);

    x_ge_b    = x >= baseline_q;
    dev       = x_ge_b ? x - baseline_q : baseline_q - x;
    step_num  = x_ge_b ? STEP_W'(dev) : STEP_W'(dev) + ROUND_UP;
    step_prod = (2*STEP_W)'(step_num) * (2*STEP_W)'(RECIP_200);
    step_q    = step_prod[RECIP_SHIFT +: QUOT_W];
    b_adj     = x_ge_b ? STEP_W'(baseline_q) + STEP_W'(step_q)
                       : STEP_W'(baseline_q) - STEP_W'(step_q);

    sample_inc = sat_inc16(sample_elapsed_q);
    window_inc = sat_inc16(window_elapsed_q);

    energy_sum = {1'b0, energy_q} + (ENERGY_W+1)'(dev);
    energy_mid = energy_q;
    if (sample_inc >= sample_ticks_q && dev > delta_min_q) begin
      energy_mid = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
    end
    vib_next = (energy_mid > energy_thresh_q) ? sat_inc16(vib_windows_q) : '0;
  end

  // Next state for one tick
  always_comb begin
    warmup_elapsed_d = sat_inc16(warmup_elapsed_q);
    baseline_done_d  = baseline_done_q;
    baseline_sum_d   = baseline_sum_q;
    baseline_taken_d = baseline_taken_q;
    baseline_d       = baseline_q;
    sample_elapsed_d = sample_elapsed_q;
    window_elapsed_d = window_elapsed_q;
    energy_d         = energy_q;
    closed_energy_d  = closed_energy_q;
    vib_windows_d    = vib_windows_q;
    detect_d         = detect_q;
    closed_d         = 1'b0;

    if (warming) begin
      sample_elapsed_d = '0;
      window_elapsed_d = '0;
      energy_d         = '0;
      closed_energy_d  = '0;
      vib_windows_d    = '0;
      detect_d         = 1'b0;
    end else if (!baseline_done_q) begin
      if (taken_inc >= CNT_W'(BASELINE_SAMPLES)) begin
        baseline_d       = avg_prod[DIV_SHIFT +: SAMPLE_W];
        baseline_done_d  = 1'b1;
        baseline_sum_d   = '0;
        baseline_taken_d = '0;
        sample_elapsed_d = '0;
        window_elapsed_d = '0;
        energy_d         = '0;
        closed_energy_d  = '0;
        vib_windows_d    = '0;
        detect_d         = 1'b0;
      end else begin
        baseline_sum_d   = sum_new;
        baseline_taken_d = taken_inc;
      end
    end else begin
      sample_elapsed_d = sample_inc;
      if (sample_inc >= sample_ticks_q) begin
        sample_elapsed_d = '0;
        baseline_d       = b_adj[SAMPLE_W-1:0];
      end
      energy_d         = energy_mid;
      window_elapsed_d = window_inc;
      if (window_inc >= window_ticks_q) begin
        window_elapsed_d = '0;
        closed_d         = 1'b1;
        closed_energy_d  = energy_mid;
        vib_windows_d    = vib_next;
        detect_d         = vib_next >= persist_req_q;
        energy_d         = '0;
      end
    end
  end

  // Advance state on each transfer; hold while the result is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warmup_elapsed_q <= '0;
      baseline_done_q  <= 1'b0;
      baseline_sum_q   <= '0;
      baseline_taken_q <= '0;
      baseline_q       <= '0;
      sample_elapsed_q <= '0;
      window_elapsed_q <= '0;
      energy_q         <= '0;
      closed_energy_q  <= '0;
      vib_windows_q    <= '0;
      detect_q         <= 1'b0;
      warming_q        <= 1'b0;
      closed_q         <= 1'b0;
    end else if (accept) begin
      warmup_elapsed_q <= warmup_elapsed_d;
      baseline_done_q  <= baseline_done_d;
      baseline_sum_q   <= baseline_sum_d;
      baseline_taken_q <= baseline_taken_d;
      baseline_q       <= baseline_d;
      sample_elapsed_q <= sample_elapsed_d;
      window_elapsed_q <= window_elapsed_d;
      energy_q         <= energy_d;
      closed_energy_q  <= closed_energy_d;
      vib_windows_q    <= vib_windows_d;
      detect_q         <= detect_d;
      warming_q        <= warming;
      closed_q         <= closed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // The state registers hold exactly the post-tick values until the next transfer
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {closed_q, vib_windows_q, closed_energy_q, energy_q,
                            baseline_q, baseline_done_q, warming_q, detect_q};

`ifndef ASSERT_OFF
  a_warm_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warming_q |-> (energy_q == '0 && vib_windows_q == '0 && !detect_q))
    else $error("runtime state not cleared on a warm-up tick");

  a_detect_needs_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    detect_q |-> baseline_done_q)
    else $error("detection without a baseline");

  a_close_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |-> (energy_q == '0 && window_elapsed_q == '0))
    else $error("window close left energy or counter behind");

  a_taken_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    baseline_taken_q < CNT_W'(BASELINE_SAMPLES))
    else $error("baseline sample count out of range");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> $stable(energy_q) && $stable(baseline_q))
    else $error("state moved while a result was stalled");
`endif

endmodule
